// ----- design/pcc_pkg.sv -----
// Shared types and constants for the pairing code checker.
`timescale 1ns / 1ps
`default_nettype none
package pcc_pkg;

	localparam int NUM_CHARS = 6;
	localparam int CODE_W = 8 * NUM_CHARS;
	localparam int LEN_W = 8;
	localparam int TIME_W = 32;
	localparam int ATT_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TIME = 1'd1;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [ATT_W-1:0] ATT_MAX = '1;

	localparam logic OP_SET_STATE = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_LOCKED    = 3'd1,
		ST_INVALID   = 3'd2,
		ST_PAIRED    = 3'd3,
		ST_NOT_READY = 3'd4
	} status_t;

	typedef struct packed {
		logic              operation;
		logic              new_paired;
		logic [CODE_W-1:0] code_chars;
		logic [LEN_W-1:0]  code_length;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [ATT_W-1:0] attempts_used;
	} result_t;

	typedef struct packed {
		logic [ATT_W-1:0]  attempt_limit;
		logic [TIME_W-1:0] lockout_time_ms;
	} cfg_t;

	// Character at a position, first character in the high byte; positions
	// past the packed word read as zero.
	function automatic logic [7:0] char_at(input logic [CODE_W-1:0] packed_code,
			input int pos);
		logic [7:0] ch;
		ch = 8'd0;
		if (pos < NUM_CHARS) begin
			ch = packed_code[8*(NUM_CHARS-1-pos) +: 8];
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

// ----- design/pcc_if.sv -----
// Valid/ready channel interfaces for check requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface pcc_in_if
	import pcc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              operation;
	logic              new_paired;
	logic [CODE_W-1:0] code_chars;
	logic [LEN_W-1:0]  code_length;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, operation, new_paired, code_chars, code_length, now_ms,
		input ready);
	modport sink (input valid, operation, new_paired, code_chars, code_length, now_ms,
		output ready);
endinterface

interface pcc_out_if
	import pcc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [2:0]       status;
	logic [ATT_W-1:0] attempts_used;

	modport source (output valid, status, attempts_used, input ready);
	modport sink (input valid, status, attempts_used, output ready);
endinterface
`default_nettype wire

// ----- design/pcc_cfg_regs.sv -----
// Configuration registers: attempt limit and lockout duration.
`timescale 1ns / 1ps
`default_nettype none
module pcc_cfg_regs
	import pcc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	logic [ATT_W-1:0]  attempt_limit_q;
	logic [TIME_W-1:0] lockout_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_limit_q <= ATT_W'(5);
			lockout_time_q <= TIME_W'(300000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ATTEMPT_LIMIT: attempt_limit_q <= cfg_data[ATT_W-1:0];
				CFG_LOCKOUT_TIME: lockout_time_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.attempt_limit = attempt_limit_q;
	assign cfg.lockout_time_ms = lockout_time_q;

endmodule
`default_nettype wire

// ----- design/pcc_eval.sv -----
// Pairing state, attempt counter and lock, with the per-item decision logic.
`timescale 1ns / 1ps
`default_nettype none
module pcc_eval
	import pcc_pkg::*;
#(
	parameter int CODE_LEN = 6
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  fire,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output result_t    res
);

	logic              is_paired_q;
	logic [CODE_W-1:0] exp_code_q;
	logic [LEN_W-1:0]  exp_len_q;
	logic [ATT_W-1:0]  wrong_q;
	logic              lock_active_q;
	logic [TIME_W-1:0] lock_end_q;

	logic              is_paired_d;
	logic [CODE_W-1:0] exp_code_d;
	logic [LEN_W-1:0]  exp_len_d;
	logic [ATT_W-1:0]  wrong_d;
	logic              lock_active_d;
	logic [TIME_W-1:0] lock_end_d;
	status_t           status_d;

	logic [TIME_W-1:0] remain;
	logic              expired;
	logic              well_formed;
	logic              same_code;
	logic [ATT_W-1:0]  wrong_base;
	logic [ATT_W-1:0]  wrong_inc;
	logic [7:0]        ch;

	always_comb begin
		remain = lock_end_q - item.now_ms;
		expired = (remain == '0) || remain[TIME_W-1];

		well_formed = (item.code_length == LEN_W'(CODE_LEN));
		for (int i = 0; i < CODE_LEN; i++) begin
			ch = char_at(item.code_chars, i);
			if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
				well_formed = 1'b0;
			end
		end

		same_code = (exp_len_q != '0) && (exp_len_q == item.code_length);
		for (int i = 0; i < NUM_CHARS; i++) begin
			if (LEN_W'(i) < item.code_length &&
					char_at(exp_code_q, i) != char_at(item.code_chars, i)) begin
				same_code = 1'b0;
			end
		end

		is_paired_d = is_paired_q;
		exp_code_d = exp_code_q;
		exp_len_d = exp_len_q;
		wrong_d = wrong_q;
		lock_active_d = lock_active_q;
		lock_end_d = lock_end_q;
		status_d = ST_OK;
		wrong_base = wrong_q;
		wrong_inc = wrong_q;

		if (item.operation == OP_SET_STATE) begin
			is_paired_d = item.new_paired;
			if (item.new_paired) begin
				exp_code_d = '0;
				exp_len_d = '0;
			end else begin
				exp_code_d = item.code_chars;
				exp_len_d = item.code_length;
				wrong_d = '0;
				lock_active_d = 1'b0;
			end
		end else if (lock_active_q && !expired) begin
			status_d = ST_LOCKED;
		end else begin
			// An expired lock is dropped and the attempt count starts over.
			if (lock_active_q) begin
				lock_active_d = 1'b0;
				wrong_base = '0;
			end
			wrong_d = wrong_base;
			wrong_inc = (wrong_base == ATT_MAX) ? wrong_base : wrong_base + ATT_W'(1);
			if (!well_formed) begin
				status_d = ST_INVALID;
			end else if (is_paired_q) begin
				status_d = ST_PAIRED;
			end else if (exp_len_q == '0) begin
				status_d = ST_NOT_READY;
			end else if (same_code) begin
				status_d = ST_OK;
				wrong_d = '0;
			end else begin
				wrong_d = wrong_inc;
				if (wrong_inc >= cfg.attempt_limit) begin
					lock_active_d = 1'b1;
					lock_end_d = item.now_ms + cfg.lockout_time_ms;
					status_d = ST_LOCKED;
				end else begin
					status_d = ST_INVALID;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_paired_q <= 1'b0;
			exp_code_q <= '0;
			exp_len_q <= '0;
			wrong_q <= '0;
			lock_active_q <= 1'b0;
			lock_end_q <= '0;
		end else if (fire) begin
			is_paired_q <= is_paired_d;
			exp_code_q <= exp_code_d;
			exp_len_q <= exp_len_d;
			wrong_q <= wrong_d;
			lock_active_q <= lock_active_d;
			lock_end_q <= lock_end_d;
		end
	end

	assign res.status = status_d;
	assign res.attempts_used = wrong_d;

	a_locked_holds_lock: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status_d == ST_LOCKED |=> lock_active_q)
		else $error("locked result without an active lock");

	a_unpair_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.operation == OP_SET_STATE && !item.new_paired
		|=> !lock_active_q && wrong_q == '0)
		else $error("unpairing left attempts or lock behind");

	a_idle_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(wrong_q) && $stable(lock_active_q) && $stable(is_paired_q))
		else $error("state changed without an item");

	a_paired_status: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.operation == OP_CHECK && status_d == ST_PAIRED |-> is_paired_q)
		else $error("already-paired status while unpaired");

endmodule
`default_nettype wire

// ----- design/pairing_code_checker_lockout.sv -----
// Top level of the pairing code checker with wrong-attempt lockout.
//
// Items arrive on the "in" channel and each yields exactly one result on the
// "out" channel, both valid/ready, moving an item on a clock edge where valid
// and ready are high. An item either sets the pairing state (operation 0) or
// checks an offered code against the stored one (operation 1) using the
// millisecond time it carries.
// An accepted item is held in the input register; the decision and state
// update then load the result register once it is empty or being emptied.
// Throughput is one item per cycle while out.ready stays high, set by the
// state update loop of the attempt counter and lock.
// The result register and the input register form a two-stage pipeline, so a
// stalled receiver holds its result while one more item is taken; when both
// stages are full, in.ready drops until out.ready returns.
// Reset clears the pairing state, stored code, attempt count and lock, and
// loads an attempt limit of 5 and a lockout of 300000 ms. The user must write
// configuration through cfg_we, cfg_index and cfg_data while no item is in
// flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module pairing_code_checker_lockout
	import pcc_pkg::*;
#(
	parameter int CODE_LEN = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	pcc_in_if.sink                     in,
	pcc_out_if.source                  out,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res;
	logic    fire;

	pcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcc_eval #(
		.CODE_LEN (CODE_LEN)
	) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign fire = valid_s1 && (!valid_s2 || out.ready);
	assign in.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in.ready) begin
				valid_s1 <= in.valid;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (out.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			item_s1.operation <= in.operation;
			item_s1.new_paired <= in.new_paired;
			item_s1.code_chars <= in.code_chars;
			item_s1.code_length <= in.code_length;
			item_s1.now_ms <= in.now_ms;
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out.valid = valid_s2;
	assign out.status = res_s2.status;
	assign out.attempts_used = res_s2.attempts_used;

endmodule
`default_nettype wire

// ----- dv/tb_pairing_code_checker_lockout.sv -----
// Self-checking testbench for the pairing code checker with wrong-attempt lockout.
`timescale 1ns / 1ps
module tb_pairing_code_checker_lockout;
	import pcc_pkg::*;

	localparam int CODE_LEN = 6;
	localparam int NUM_PHASES = 7;
	localparam int PHASE_ITEMS = 218;
	localparam int CYCLE_LIMIT = 100000;
	localparam int HOLD_AT = 1000;
	localparam int HOLD_CYCLES = 90;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pcc_in_if in_ch ();
	pcc_out_if out_ch ();

	pairing_code_checker_lockout #(
		.CODE_LEN(CODE_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch),
		.out(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	item_t request_q[$];
	result_t verdict_q[$];

	logic paired_q;
	logic [CODE_W-1:0] stored_code;
	logic [LEN_W-1:0] stored_len;
	logic [ATT_W-1:0] wrong_cnt;
	logic lock_on;
	logic [TIME_W-1:0] lock_end;
	logic [ATT_W-1:0] att_limit;
	logic [TIME_W-1:0] lock_ms;

	logic [CODE_W-1:0] sess_code;
	logic [TIME_W-1:0] ms_now;

	int accepted_n;
	int checked_n;
	int mismatch_n = 0;
	int cycle_n = 0;
	int hold_left;
	logic hold_done;
	logic calm;
	item_t next_item;
	item_t taken_item;
	result_t verdict;
	result_t want;

	int unsigned ph_limit[NUM_PHASES] = '{1, 255, 3, 2, 5, 4, 8};
	logic [31:0] ph_lock[NUM_PHASES] = '{32'd1, 32'hFFFF_FFFF, 32'd20, 32'h7FFF_FFFF,
		32'h8000_0000, 32'd100, 32'd37};
	int unsigned ph_step[NUM_PHASES] = '{2, 50, 8, 1000, 1000, 40, 15};
	logic [31:0] ph_start[NUM_PHASES] = '{32'd0, 32'hFFFF_FF00, 32'd5000, 32'h7FFF_FF00,
		32'hFFFF_F000, 32'd123456, 32'hFFFF_FFF0};

	assign calm = (accepted_n >= 600) && (accepted_n < 800);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [CODE_W-1:0] digits(input int unsigned v);
		logic [CODE_W-1:0] c;
		int k;
		for (k = 0; k < NUM_CHARS; k++) begin
			c[8*k +: 8] = CHAR_ZERO + 8'(v % 10);
			v = v / 10;
		end
		return c;
	endfunction

	function automatic logic [CODE_W-1:0] rand_bits48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[CODE_W-1:0];
	endfunction

	function automatic item_t mk_set(input logic paired, input logic [CODE_W-1:0] code,
			input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] now);
		item_t it;
		it.operation = OP_SET_STATE;
		it.new_paired = paired;
		it.code_chars = code;
		it.code_length = len;
		it.now_ms = now;
		return it;
	endfunction

	function automatic item_t mk_check(input logic [CODE_W-1:0] code,
			input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] now);
		item_t it;
		it.operation = OP_CHECK;
		it.new_paired = 1'b0;
		it.code_chars = code;
		it.code_length = len;
		it.now_ms = now;
		return it;
	endfunction

	task automatic add_request(input item_t it);
		request_q = {request_q, it};
	endtask

	task automatic grade_item(input item_t it, output result_t res);
		logic [TIME_W-1:0] gap;
		logic shaped;
		logic same;
		status_t st;
		int k;
		st = ST_OK;
		if (it.operation == OP_SET_STATE) begin
			paired_q = it.new_paired;
			if (it.new_paired) begin
				stored_code = '0;
				stored_len = '0;
			end else begin
				stored_code = it.code_chars;
				stored_len = it.code_length;
				wrong_cnt = '0;
				lock_on = 1'b0;
			end
		end else begin
			if (lock_on) begin
				gap = lock_end - it.now_ms;
				if (gap == '0 || gap[TIME_W-1]) begin
					lock_on = 1'b0;
					wrong_cnt = '0;
				end
			end
			shaped = (it.code_length == LEN_W'(CODE_LEN));
			for (k = 0; k < CODE_LEN; k++) begin
				if (char_at(it.code_chars, k) < CHAR_ZERO ||
						char_at(it.code_chars, k) > CHAR_NINE)
					shaped = 1'b0;
			end
			same = (stored_len != '0) && (stored_len == it.code_length);
			for (k = 0; k < NUM_CHARS; k++) begin
				if (LEN_W'(k) < it.code_length &&
						char_at(stored_code, k) != char_at(it.code_chars, k))
					same = 1'b0;
			end
			if (lock_on) begin
				st = ST_LOCKED;
			end else if (!shaped) begin
				st = ST_INVALID;
			end else if (paired_q) begin
				st = ST_PAIRED;
			end else if (stored_len == '0) begin
				st = ST_NOT_READY;
			end else if (same) begin
				wrong_cnt = '0;
				st = ST_OK;
			end else begin
				if (wrong_cnt != ATT_MAX)
					wrong_cnt = wrong_cnt + 1'b1;
				if (wrong_cnt >= att_limit) begin
					lock_on = 1'b1;
					lock_end = it.now_ms + lock_ms;
					st = ST_LOCKED;
				end else begin
					st = ST_INVALID;
				end
			end
		end
		res.status = st;
		res.attempts_used = wrong_cnt;
	endtask

	task automatic gen_item(input int unsigned step_max, output item_t it);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0)
			ms_now = $urandom;
		else
			ms_now = ms_now + $urandom_range(0, step_max);
		it = mk_check(digits($urandom_range(0, 999999)), LEN_W'(CODE_LEN), ms_now);
		it.new_paired = 1'($urandom_range(0, 1));
		if (pick < 6) begin
			sess_code = digits($urandom_range(0, 999999));
			it = mk_set(1'b0, sess_code, LEN_W'(CODE_LEN), $urandom);
		end else if (pick < 8) begin
			it = mk_set(1'b1, rand_bits48(), LEN_W'($urandom_range(0, 255)), $urandom);
		end else if (pick < 10) begin
			it = mk_set(1'b0, rand_bits48(), LEN_W'($urandom_range(0, 255)), ms_now);
		end else if (pick < 13) begin
			it.operation = 1'($urandom_range(0, 1));
			it.code_chars = rand_bits48();
			it.code_length = LEN_W'($urandom_range(0, 255));
			it.now_ms = $urandom;
		end else if (pick < 45) begin
			it.code_chars = sess_code;
		end else if (pick >= 88) begin
			if ($urandom_range(0, 1) == 0)
				it.code_chars = rand_bits48();
			else
				it.code_length = LEN_W'($urandom_range(0, 255));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_ATTEMPT_LIMIT)
			att_limit = val[ATT_W-1:0];
		else
			lock_ms = val;
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned exp_val);
		$display("mismatch in %s at result %0d: got %0d, expected %0d",
			what, checked_n, got, exp_val);
		mismatch_n++;
	endtask

	task automatic wait_drained();
		while (request_q.size() != 0 || in_ch.valid || verdict_q.size() != 0)
			@(posedge clk);
	endtask

	// Driver: offers the next pending item and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.operation <= OP_SET_STATE;
			in_ch.new_paired <= 1'b0;
			in_ch.code_chars <= '0;
			in_ch.code_length <= '0;
			in_ch.now_ms <= '0;
			accepted_n <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				taken_item.operation = in_ch.operation;
				taken_item.new_paired = in_ch.new_paired;
				taken_item.code_chars = in_ch.code_chars;
				taken_item.code_length = in_ch.code_length;
				taken_item.now_ms = in_ch.now_ms;
				grade_item(taken_item, verdict);
				verdict_q = {verdict_q, verdict};
				accepted_n <= accepted_n + 1;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (request_q.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
					next_item = request_q.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.operation <= next_item.operation;
					in_ch.new_paired <= next_item.new_paired;
					in_ch.code_chars <= next_item.code_chars;
					in_ch.code_length <= next_item.code_length;
					in_ch.now_ms <= next_item.now_ms;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver hold-off: one long stall so the pipeline fills and blocks its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_n >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			checked_n <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("unexpected result", out_ch.status, 0);
				end else begin
					want = verdict_q.pop_front();
					if (out_ch.status != want.status)
						report_mismatch("status", out_ch.status, want.status);
					if (out_ch.attempts_used != want.attempts_used)
						report_mismatch("attempts_used", out_ch.attempts_used,
							want.attempts_used);
				end
				checked_n <= checked_n + 1;
			end
			out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 14);
		end
	end

	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
		if (cycle_n >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		item_t it;
		int p;
		int n;
		paired_q = 1'b0;
		stored_code = '0;
		stored_len = '0;
		wrong_cnt = '0;
		lock_on = 1'b0;
		lock_end = '0;
		att_limit = 8'd5;
		lock_ms = 32'd300000;
		sess_code = digits(0);
		ms_now = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ATTEMPT_LIMIT;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, run with the reset configuration.
		add_request(mk_check(digits(123456), 6, 1000));
		add_request(mk_set(1'b0, digits(0), 6, 1001));
		add_request(mk_check(digits(0), 6, 1002));
		add_request(mk_set(1'b0, digits(999999), 6, 1003));
		add_request(mk_check(digits(999999), 5, 1004));
		add_request(mk_check(digits(999999), 0, 1005));
		add_request(mk_check(digits(999999), 255, 1006));
		add_request(mk_check(digits(999999), 7, 1007));
		add_request(mk_check({8'h2F, {5{CHAR_NINE}}}, 6, 1008));
		add_request(mk_check({{5{CHAR_NINE}}, 8'h3A}, 6, 1009));
		add_request(mk_check('1, 6, 1010));
		add_request(mk_check('0, 6, 1011));
		add_request(mk_check(digits(999999), 6, 1012));
		for (n = 0; n < 4; n++)
			add_request(mk_check(digits(111111), 6, 2000 + n));
		add_request(mk_check(digits(123450), 6, 2004));
		add_request(mk_check(digits(999999), 6, 2005));
		add_request(mk_set(1'b1, digits(999999), 6, 0));
		add_request(mk_check(digits(999999), 6, 302004));
		add_request(mk_set(1'b0, digits(123456), 7, 0));
		add_request(mk_check(digits(123456), 6, 302005));
		add_request(mk_set(1'b0, '0, 0, 0));
		add_request(mk_check(digits(123456), 6, 302006));
		wait_drained();

		for (p = 0; p < NUM_PHASES; p++) begin
			write_reg(CFG_ATTEMPT_LIMIT, ph_limit[p]);
			write_reg(CFG_LOCKOUT_TIME, ph_lock[p]);
			@(posedge clk);
			cfg_we <= 1'b0;
			ms_now = ph_start[p];
			sess_code = digits($urandom_range(0, 999999));
			add_request(mk_set(1'b0, sess_code, LEN_W'(CODE_LEN), ms_now));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				gen_item(ph_step[p], it);
				add_request(it);
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (verdict_q.size() != 0)
			report_mismatch("results never arrived", 0, verdict_q.size());
		if (mismatch_n == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
